// ===== src/mbet_pkg.sv =====
`timescale 1ns / 1ps

package mbet_pkg;

    // Fixed-point format
    localparam int FRAC_BITS = 28;
    localparam int ACC_BITS  = FRAC_BITS + 8;

    // Field and register widths
    localparam int ITER_BITS = 16;
    localparam int PIX_W     = 12;
    localparam int DIM_W     = 13;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int MAX_DIM   = 4096;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 2'd2;

    // Coordinate divider: numerator is |2p - d| * 2^(FRAC_BITS+2) + w, divisor 2w
    localparam int DIFF_W    = DIM_W + 1;
    localparam int MAG_W     = DIM_W;
    localparam int NUM_W     = MAG_W + FRAC_BITS + 2;
    localparam int DEN_W     = DIM_W + 1;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    // Shared multiplier: full operand times half operand
    localparam int MUL_LO = ACC_BITS / 2;
    localparam int MUL_HI = ACC_BITS - MUL_LO;
    localparam int PP_W   = ACC_BITS + MUL_HI;
    localparam int PROD_W = 2 * ACC_BITS;
    localparam int SUM_W  = ACC_BITS + 2;

    localparam logic [ACC_BITS-1:0] WORD_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic [ACC_BITS-1:0] WORD_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
    localparam logic [ACC_BITS-1:0] FOUR_FX  =
        {{5{1'b0}}, 1'b1, {(FRAC_BITS+2){1'b0}}};

    typedef struct packed {
        logic [PIX_W-1:0] pixel_col;
        logic [PIX_W-1:0] pixel_row;
    } t_pixel_in;

    typedef struct packed {
        logic [ITER_BITS-1:0] iter_count;
        logic                 escaped;
    } t_pixel_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_ROUND,
        ST_CHECK,
        ST_MUL,
        ST_UPDATE,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_XX,
        OP_YY,
        OP_XY
    } t_mop;

    // Apply sign to a magnitude and clip to the word range
    function automatic logic [ACC_BITS-1:0] sat_signed(input logic neg,
                                                       input logic [PROD_W-1:0] mag);
        logic [ACC_BITS-1:0] res;
        if (neg) begin
            if (mag > PROD_W'(WORD_MIN)) res = WORD_MIN;
            else res = -mag[ACC_BITS-1:0];
        end else begin
            if (mag > PROD_W'(WORD_MAX)) res = WORD_MAX;
            else res = mag[ACC_BITS-1:0];
        end
        return res;
    endfunction

    // Clip a widened signed sum to the word range
    function automatic logic [ACC_BITS-1:0] sat_word(input logic signed [SUM_W-1:0] v);
        logic [ACC_BITS-1:0] res;
        if (v > $signed({2'b00, WORD_MAX})) res = WORD_MAX;
        else if (v < $signed({2'b11, WORD_MIN})) res = WORD_MIN;
        else res = v[ACC_BITS-1:0];
        return res;
    endfunction

endpackage

// ===== src/mandelbrot_escape_time.sv =====
// Channel  Direction  Payload      Handshake
// in       input      t_pixel_in   i_in_valid / o_in_stall
// out      output     t_pixel_out  o_out_valid / i_out_stall
// cfg      input      16-bit data  i_cfg_we, i_cfg_index (write only)
//
// An item holds the core from accept to next accept, for n iterations run and the limit
// reached: the idle state, the bit-serial divider for each part of c, per iteration a
// limit check, the shared 36x18 multiplier and an update, one last check and one load of
// the output register; an escaping point adds the round that tests it.
// Reset is synchronous, active low; it restores the register reset values. Input waits
// until the core is idle; the core holds in its last state while a result is stalled.
`timescale 1ns / 1ps

module mandelbrot_escape_time
    import mbet_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_pixel_in            i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_pixel_out           o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_state r_state, n_state;

    logic [DIM_W-1:0]     r_image_width;
    logic [DIM_W-1:0]     r_image_height;
    logic [ITER_BITS-1:0] r_iteration_limit;

    t_pixel_in            r_pix;
    logic                 r_coord_sel;
    logic [NUM_W-1:0]     r_div_num;
    logic [DEN_W-1:0]     r_div_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic                 r_div_neg;

    logic [ACC_BITS-1:0]  r_c_re, r_c_im, r_x, r_y, r_xx, r_yy, r_xy2;
    logic [ITER_BITS-1:0] r_count;

    t_mop                 r_mop;
    logic [1:0]           r_mstep;
    logic [PP_W-1:0]      r_pp;
    logic [PROD_W-1:0]    r_acc;

    logic                 r_out_valid;
    t_pixel_out           r_out_item;

    logic in_accept, out_free, out_load;

    // Clamp the image size to 1..MAX_DIM
    logic [DIM_W-1:0] w_dim, h_dim;
    always_comb begin
        if (r_image_width == '0) w_dim = DIM_W'(1);
        else if (r_image_width > DIM_W'(MAX_DIM)) w_dim = DIM_W'(MAX_DIM);
        else w_dim = r_image_width;
        if (r_image_height == '0) h_dim = DIM_W'(1);
        else if (r_image_height > DIM_W'(MAX_DIM)) h_dim = DIM_W'(MAX_DIM);
        else h_dim = r_image_height;
    end

    // Divider operands for the current coordinate
    logic [PIX_W-1:0]         p_sel;
    logic [DIM_W-1:0]         d_sel;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        diff_abs;
    logic [NUM_W-1:0]         num_init;
    logic [DEN_W-1:0]         div_den;
    logic [DEN_W:0]           div_shift, div_sub;
    logic                     div_ge;
    logic [DEN_W-1:0]         div_rem_next;
    logic [ACC_BITS-1:0]      c_val;

    always_comb begin
        p_sel        = r_coord_sel ? r_pix.pixel_row : r_pix.pixel_col;
        d_sel        = r_coord_sel ? h_dim : w_dim;
        diff         = $signed({1'b0, p_sel, 1'b0}) - $signed({1'b0, d_sel});
        diff_abs     = diff[DIFF_W-1] ? -diff : diff;
        num_init     = {diff_abs[MAG_W-1:0], {(FRAC_BITS+2){1'b0}}} + NUM_W'(w_dim);
        div_den      = {w_dim, 1'b0};
        div_shift    = {r_div_rem, r_div_num[NUM_W-1]};
        div_sub      = div_shift - {1'b0, div_den};
        div_ge       = div_shift >= {1'b0, div_den};
        div_rem_next = div_ge ? div_sub[DEN_W-1:0] : div_shift[DEN_W-1:0];
        c_val        = sat_signed(r_div_neg, PROD_W'(r_div_num));
    end

    // Shared multiplier: operand select, magnitude, and half of the second operand
    logic [ACC_BITS-1:0] op_a, op_b, a_mag, b_mag;
    logic [MUL_HI-1:0]   b_part;
    logic [PP_W-1:0]     mul_out;
    logic                mul_neg;
    logic [PROD_W-1:0]   q_full, q_inc;
    logic                rem_nz;
    logic [ACC_BITS-1:0] mul_res;

    always_comb begin
        op_a    = (r_mop == OP_YY) ? r_y : r_x;
        op_b    = (r_mop == OP_XX) ? r_x : r_y;
        a_mag   = op_a[ACC_BITS-1] ? -op_a : op_a;
        b_mag   = op_b[ACC_BITS-1] ? -op_b : op_b;
        b_part  = (r_mstep == 2'd0) ? MUL_HI'(b_mag[MUL_LO-1:0]) : b_mag[ACC_BITS-1:MUL_LO];
        mul_out = a_mag * b_part;
        mul_neg = op_a[ACC_BITS-1] ^ op_b[ACC_BITS-1];
        // Floor shift: magnitude rounds up for a negative product
        if (r_mop == OP_XY) begin
            q_full = r_acc >> (FRAC_BITS - 1);
            rem_nz = |r_acc[FRAC_BITS-2:0];
        end else begin
            q_full = r_acc >> FRAC_BITS;
            rem_nz = |r_acc[FRAC_BITS-1:0];
        end
        q_inc   = q_full + PROD_W'(mul_neg & rem_nz);
        mul_res = sat_signed(mul_neg, q_inc);
    end

    // Escape test and next z
    logic signed [ACC_BITS:0] sum_sq;
    logic                     escape;
    logic [ACC_BITS-1:0]      x_next, y_next;

    always_comb begin
        sum_sq = $signed({r_xx[ACC_BITS-1], r_xx}) + $signed({r_yy[ACC_BITS-1], r_yy});
        escape = sum_sq > $signed({1'b0, FOUR_FX});
        x_next = sat_word($signed({{2{r_xx[ACC_BITS-1]}}, r_xx})
                        - $signed({{2{r_yy[ACC_BITS-1]}}, r_yy})
                        + $signed({{2{r_c_re[ACC_BITS-1]}}, r_c_re}));
        y_next = sat_word($signed({{2{r_xy2[ACC_BITS-1]}}, r_xy2})
                        + $signed({{2{r_c_im[ACC_BITS-1]}}, r_c_im}));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_accept) n_state = ST_PREP;
            ST_PREP:   n_state = ST_DIV;
            ST_DIV:    if (r_div_cnt == DIV_CNT_W'(NUM_W - 1)) n_state = ST_ROUND;
            ST_ROUND:  n_state = r_coord_sel ? ST_CHECK : ST_PREP;
            ST_CHECK:  n_state = (r_count < r_iteration_limit) ? ST_MUL : ST_DONE;
            ST_MUL:    if (r_mstep == 2'd3 && r_mop == OP_XY) n_state = ST_UPDATE;
            ST_UPDATE: n_state = escape ? ST_DONE : ST_CHECK;
            ST_DONE:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        in_accept   = i_in_valid && (r_state == ST_IDLE);
        out_free    = !r_out_valid || !i_out_stall;
        out_load    = (r_state == ST_DONE) && out_free;
        o_out_valid = r_out_valid;
        o_out_item  = r_out_item;
    end

    // Control state, configuration and sequencer counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ST_IDLE;
            r_image_width     <= DIM_W'(640);
            r_image_height    <= DIM_W'(480);
            r_iteration_limit <= ITER_BITS'(256);
            r_out_valid       <= 1'b0;
            r_coord_sel       <= 1'b0;
            r_div_cnt         <= '0;
            r_mstep           <= '0;
            r_mop             <= OP_XX;
        end else begin
            r_state <= n_state;

            // Take register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:     r_image_width     <= i_cfg_data[DIM_W-1:0];
                    CFG_IMAGE_HEIGHT:    r_image_height    <= i_cfg_data[DIM_W-1:0];
                    CFG_ITERATION_LIMIT: r_iteration_limit <= i_cfg_data[ITER_BITS-1:0];
                    default: ;
                endcase
            end

            // Hold the result until taken
            if (out_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;

            case (r_state)
                ST_IDLE:  r_coord_sel <= 1'b0;
                ST_PREP:  r_div_cnt <= '0;
                ST_DIV:   r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
                ST_ROUND: r_coord_sel <= 1'b1;
                ST_CHECK: begin
                    r_mop   <= OP_XX;
                    r_mstep <= '0;
                end
                ST_MUL: begin
                    r_mstep <= r_mstep + 2'd1;
                    if (r_mstep == 2'd3) begin
                        case (r_mop)
                            OP_XX:   r_mop <= OP_YY;
                            OP_YY:   r_mop <= OP_XY;
                            default: r_mop <= r_mop;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_accept) r_pix <= i_in_item;
            end
            ST_PREP: begin
                r_div_num <= num_init;
                r_div_rem <= '0;
                r_div_neg <= diff[DIFF_W-1];
            end
            ST_DIV: begin
                r_div_num <= {r_div_num[NUM_W-2:0], div_ge};
                r_div_rem <= div_rem_next;
            end
            ST_ROUND: begin
                if (!r_coord_sel) begin
                    r_c_re <= c_val;
                end else begin
                    r_c_im  <= c_val;
                    r_x     <= '0;
                    r_y     <= '0;
                    r_count <= '0;
                end
            end
            ST_MUL: begin
                case (r_mstep)
                    2'd0: r_pp <= mul_out;
                    2'd1: begin
                        r_acc <= PROD_W'(r_pp);
                        r_pp  <= mul_out;
                    end
                    2'd2: r_acc <= r_acc + (PROD_W'(r_pp) << MUL_LO);
                    default: begin
                        case (r_mop)
                            OP_XX:   r_xx  <= mul_res;
                            OP_YY:   r_yy  <= mul_res;
                            default: r_xy2 <= mul_res;
                        endcase
                    end
                endcase
            end
            ST_UPDATE: begin
                if (!escape) begin
                    r_x     <= x_next;
                    r_y     <= y_next;
                    r_count <= r_count + ITER_BITS'(1);
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    r_out_item.iter_count <= r_count;
                    r_out_item.escaped    <= (r_count < r_iteration_limit);
                end
            end
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_PREP))
        else $error("accepted item did not start coordinate setup");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_div_rem < div_den))
        else $error("divider remainder not below divisor");

    a_mul_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_count < r_iteration_limit))
        else $error("iteration started at or past the limit");

    a_squares_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |-> (!r_xx[ACC_BITS-1] && !r_yy[ACC_BITS-1]))
        else $error("square came out negative");

    a_escaped_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.escaped) |-> (o_out_item.iter_count < r_iteration_limit))
        else $error("escaped item with count at the limit");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import mbet_pkg::*;

    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int IDLE_LIMIT  = 20000;
    localparam int TAIL_CYCLES = 300;
    localparam int SEARCH_CAP  = 100;
    localparam int PHASES      = 16;
    localparam int PHASE_ITEMS = 96;

    localparam longint WORD_HI   = (longint'(1) <<< (ACC_BITS - 1)) - 1;
    localparam longint WORD_LO   = -WORD_HI - 1;
    localparam longint FOUR_WORD = longint'(4) <<< FRAC_BITS;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_pixel_in            in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b1;
    t_pixel_out           out_item;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    bit in_calm  = 1'b0;
    bit out_calm = 1'b0;
    int sent     = 0;
    int idle_run = 0;

    mandelbrot_escape_time dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Escape-time predictor and queue of expected counts
    class escape_scoreboard;
        logic [DIM_W-1:0]     width_reg;
        logic [DIM_W-1:0]     height_reg;
        logic [ITER_BITS-1:0] limit_reg;
        t_pixel_out           expected_q[$];
        int                   mismatches;

        function new();
            width_reg  = DIM_W'(640);
            height_reg = DIM_W'(480);
            limit_reg  = ITER_BITS'(256);
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH:     width_reg  = data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:    height_reg = data[DIM_W-1:0];
                CFG_ITERATION_LIMIT: limit_reg  = data[ITER_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp_dim(logic [DIM_W-1:0] d);
            if (d == 0) return 1;
            if (d > MAX_DIM) return MAX_DIM;
            return d;
        endfunction

        function int unsigned eff_width();
            return clamp_dim(width_reg);
        endfunction

        function int unsigned eff_height();
            return clamp_dim(height_reg);
        endfunction

        function longint clip_word(logic signed [127:0] v);
            if (v > WORD_HI) return WORD_HI;
            if (v < WORD_LO) return WORD_LO;
            return longint'(v);
        endfunction

        // Full product, floor shift, clip
        function longint scaled_product(longint a, longint b, int sh);
            logic signed [127:0] p;
            p = a;
            p = p * b;
            return clip_word(p >>> sh);
        endfunction

        // Round (2*pos - span) * 2^(FRAC_BITS+1) / w to nearest, ties away from zero
        function longint plane_coord(int unsigned pos, int unsigned span, int unsigned w);
            longint          diff;
            longint unsigned mag;
            longint unsigned q;
            diff = 2 * longint'(pos) - longint'(span);
            mag  = (diff < 0) ? -diff : diff;
            mag  = mag << (FRAC_BITS + 1);
            q    = (2 * mag + w) / (2 * longint'(w));
            if (diff < 0) begin
                if (q > WORD_HI + 1) return WORD_LO;
                return -longint'(q);
            end
            if (q > WORD_HI) return WORD_HI;
            return longint'(q);
        endfunction

        function int unsigned escape_count(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row,
                                           int unsigned cap);
            int unsigned w, h, n;
            longint      c_re, c_im, x, y, xx, yy, xy2;
            w    = eff_width();
            h    = eff_height();
            c_re = plane_coord(col, w, w);
            c_im = plane_coord(row, h, w);
            x    = 0;
            y    = 0;
            n    = 0;
            while (n < cap) begin
                xx = scaled_product(x, x, FRAC_BITS);
                yy = scaled_product(y, y, FRAC_BITS);
                if (clip_word(xx + yy) > FOUR_WORD) break;
                xy2 = scaled_product(x, y, FRAC_BITS - 1);
                x   = clip_word(xx - yy + c_re);
                y   = clip_word(xy2 + c_im);
                n++;
            end
            return n;
        endfunction

        function void note_pixel(t_pixel_in px);
            t_pixel_out  want;
            int unsigned n;
            n               = escape_count(px.pixel_col, px.pixel_row, limit_reg);
            want.iter_count = n[ITER_BITS-1:0];
            want.escaped    = (n < limit_reg);
            expected_q.insert(expected_q.size(), want);
        endfunction

        function void check_result(t_pixel_out got);
            t_pixel_out want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: iter_count %0d escaped %0d",
                       got.iter_count, got.escaped);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.iter_count !== want.iter_count) begin
                $error("iter_count: expected %0d, got %0d", want.iter_count, got.iter_count);
                mismatches++;
            end
            if (got.escaped !== want.escaped) begin
                $error("escaped: expected %0d, got %0d", want.escaped, got.escaped);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    escape_scoreboard sb;

    initial begin
        forever #6 clk = ~clk;
    end

    // Abort when no item moves on either channel for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_run = 0;
        end else begin
            idle_run++;
            if (idle_run >= IDLE_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // Write one register; entered and left at a falling edge
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        sb.set_reg(idx, data);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                             logic [CFG_W-1:0] lim);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_ITERATION_LIMIT, lim);
    endtask

    // Offer one item after a random gap and hold it until taken
    task automatic send_pixel(t_pixel_in px);
        int gap;
        if (sent % 40 == 0) in_calm = ($urandom_range(3, 0) == 0);
        gap = in_calm ? 0 : $urandom_range(13, 0);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= px;
        do @(posedge clk); while (in_stall);
        sb.note_pixel(px);
        sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait for every expected count
    task automatic end_phase();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge clk);
    endtask

    function automatic t_pixel_in pixel_at(int col, int row);
        t_pixel_in px;
        px.pixel_col = PIX_W'(col);
        px.pixel_row = PIX_W'(row);
        return px;
    endfunction

    // Mostly in-image pixels, some anywhere; under a large limit keep only fast escapes
    function automatic t_pixel_in random_pixel();
        t_pixel_in px;
        for (int t = 0; t < 8; t++) begin
            if ($urandom_range(9, 0) == 0) begin
                px.pixel_col = PIX_W'($urandom);
                px.pixel_row = PIX_W'($urandom);
            end else begin
                px.pixel_col = PIX_W'($urandom_range(sb.eff_width() - 1, 0));
                px.pixel_row = PIX_W'($urandom_range(sb.eff_height() - 1, 0));
            end
            if (sb.limit_reg <= SEARCH_CAP ||
                sb.escape_count(px.pixel_col, px.pixel_row, SEARCH_CAP) < SEARCH_CAP)
                return px;
        end
        // Far right of the plane escapes within a few steps
        px.pixel_col = '1;
        return px;
    endfunction

    function automatic logic [CFG_W-1:0] draw_dim();
        case ($urandom_range(5, 0))
            0:       return CFG_W'($urandom_range(16, 1));
            1, 2:    return CFG_W'($urandom_range(1024, 64));
            3:       return CFG_W'($urandom_range(4096, 1024));
            4:       return CFG_W'(MAX_DIM);
            default: return CFG_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] draw_limit();
        int r;
        r = $urandom_range(9, 0);
        if (r < 7) return CFG_W'($urandom_range(32, 1));
        if (r < 9) return CFG_W'($urandom_range(100, 1));
        return ($urandom_range(1, 0) == 1) ? 16'hFFFF : CFG_W'($urandom);
    endfunction

    // Result side: random stall before each item
    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        @(negedge clk);
        forever begin
            if (taken % 40 == 0) out_calm = ($urandom_range(3, 0) == 0);
            gap = out_calm ? 0 : $urandom_range(13, 0);
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            sb.check_result(out_item);
            taken++;
            @(negedge clk);
        end
    end

    initial begin
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration: corners, center, real axis tip, out of image, bit patterns
        send_pixel(pixel_at(0, 0));
        send_pixel(pixel_at(4095, 4095));
        send_pixel(pixel_at(320, 240));
        send_pixel(pixel_at(0, 240));
        send_pixel(pixel_at(639, 479));
        send_pixel(pixel_at(4095, 0));
        send_pixel(pixel_at(12'hAAA, 12'h555));
        send_pixel(pixel_at(12'h555, 12'hAAA));
        end_phase();

        // Smallest image and limit: c saturates, runaway points
        configure(16'd1, 16'd1, 16'd1);
        send_pixel(pixel_at(0, 0));
        send_pixel(pixel_at(4095, 4095));
        send_pixel(pixel_at(0, 4095));
        end_phase();

        // Zero sizes and zero limit, plus a write to the spare index
        configure(16'd0, 16'd0, 16'd0);
        write_reg(CFG_SPARE, 16'hFFFF);
        send_pixel(pixel_at(1, 1));
        send_pixel(pixel_at(4095, 4095));
        end_phase();

        // Oversized width, largest height and limit, fast-escaping points only
        configure(16'hFFFF, 16'(MAX_DIM), 16'hFFFF);
        send_pixel(pixel_at(4095, 4095));
        send_pixel(pixel_at(0, 0));
        send_pixel(pixel_at(4095, 0));
        send_pixel(pixel_at(0, 4095));
        end_phase();

        // Widest image over a single row
        configure(16'(MAX_DIM), 16'd1, 16'd64);
        send_pixel(pixel_at(2048, 0));
        send_pixel(pixel_at(1024, 4095));
        send_pixel(pixel_at(3071, 2));
        end_phase();

        // Random phases
        for (int ph = 0; ph < PHASES; ph++) begin
            configure(draw_dim(), draw_dim(), draw_limit());
            if ($urandom_range(3, 0) == 0) write_reg(CFG_SPARE, CFG_W'($urandom));
            for (int k = 0; k < PHASE_ITEMS; k++) send_pixel(random_pixel());
            end_phase();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
